@@ hdl/pls_pkg.sv @@
// pls_pkg: shared types and constants of the positional list store.
// Used by pls_cell and positional_list_store; depends on nothing.
`default_nettype none

package pls_pkg;

  localparam int CapacityDef = 16;
  localparam int DataW       = 32;

  typedef enum logic [2:0] {
    OP_INSERT  = 3'd0,
    OP_UPDATE  = 3'd1,
    OP_DELETE  = 3'd2,
    OP_REVERSE = 3'd3,
    OP_PRINT   = 3'd4
  } func_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_BADPOS = 2'd1,
    ST_FULL   = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_WRITE,
    CELL_DELETE,
    CELL_ROTATE
  } cell_op_e;

  typedef struct packed {
    cell_op_e           op;
    logic [DataW-1:0]   value;
    logic [DataW-1:0]   head;
  } cell_cmd_t;

endpackage

`default_nettype wire

@@ hdl/pls_cell.sv @@
// pls_cell: one list entry of the cell row; takes its neighbor's word,
// a new word or the head word according to the broadcast command.
// Depends on pls_pkg.
`default_nettype none

module pls_cell #(
  parameter int IdxW  = 4,
  parameter int Index = 0
) (
  input  wire logic                     clk_i,
  input  wire pls_pkg::cell_cmd_t       cmd_i,
  input  wire logic [IdxW-1:0]          idx_i,
  input  wire logic [pls_pkg::DataW-1:0] left_i,
  input  wire logic [pls_pkg::DataW-1:0] right_i,
  output logic      [pls_pkg::DataW-1:0] data_o
);

  localparam logic [IdxW-1:0] IdxV = IdxW'(Index);

  logic [pls_pkg::DataW-1:0] data_q, data_d;

  always_comb begin
    data_d = data_q;
    unique case (cmd_i.op)
      pls_pkg::CELL_HOLD: data_d = data_q;
      pls_pkg::CELL_INSERT: begin
        if (IdxV > idx_i) data_d = left_i;
        else if (IdxV == idx_i) data_d = cmd_i.value;
      end
      pls_pkg::CELL_WRITE: begin
        if (IdxV == idx_i) data_d = cmd_i.value;
      end
      pls_pkg::CELL_DELETE: begin
        if (IdxV >= idx_i) data_d = right_i;
      end
      pls_pkg::CELL_ROTATE: begin
        if (IdxV < idx_i) data_d = right_i;
        else if (IdxV == idx_i) data_d = cmd_i.head;
      end
      default: data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

`default_nettype wire

@@ hdl/positional_list_store.sv @@
// positional_list_store: bounded ordered list kept in a row of cells, with
// the operation sequencer and result register. Depends on pls_pkg, pls_cell.
//
//   port group        dir  handshake
//   start/func/pos/v  in   taken at an edge with start_i high, busy_o low
//   valid/results     out  one cycle per word, marked by valid_o
//
// Insert, update, delete and unknown codes: word in the next cycle.
// Print: one word per entry, or a single word flagged empty when empty.
// Reverse: a single word once the walk ends; no walk when count is below two.
// Both walk the cell row, which rotates by one place per cycle.
// Reset clears the count; entry contents are undefined until written.
// The receiver cannot stall; busy_o holds off new words during print/reverse.
`default_nettype none

module positional_list_store #(
  parameter int CAPACITY = pls_pkg::CapacityDef,
  localparam int IW = $clog2(CAPACITY),
  localparam int CW = $clog2(CAPACITY + 1)
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             start_i,
  output logic                                  busy_o,
  input  wire logic [2:0]                       func_i,
  input  wire logic [CW-1:0]                    position_i,
  input  wire logic signed [pls_pkg::DataW-1:0] value_in_i,
  output logic                                  valid_o,
  output logic [1:0]                            status_o,
  output logic signed [pls_pkg::DataW-1:0]      value_out_o,
  output logic [IW-1:0]                         entry_pos_o,
  output logic                                  is_last_o,
  output logic                                  list_empty_o,
  output logic [CW-1:0]                         entry_count_o
);

  localparam logic [CW-1:0] CapW = CW'(CAPACITY);

  typedef enum logic [1:0] {
    S_IDLE,
    S_PRINT,
    S_REV
  } state_e;

  state_e                    state_q, state_d;
  logic [CW-1:0]             count_q, count_d;
  logic [IW-1:0]             ptr_q, ptr_d;
  logic                      valid_q, valid_d;
  pls_pkg::status_e          status_q, status_d;
  logic [pls_pkg::DataW-1:0] value_q, value_d;
  logic [IW-1:0]             epos_q, epos_d;
  logic                      last_q, last_d;
  logic                      empty_q, empty_d;

  pls_pkg::cell_cmd_t        cmd;
  logic [IW-1:0]             cell_idx;
  logic [pls_pkg::DataW-1:0] cell_data [CAPACITY];
  logic [CW-1:0]             cnt_dec;
  logic [IW-1:0]             cnt_m1;
  logic                      accept;

  assign busy_o  = (state_q != S_IDLE);
  assign accept  = start_i && !busy_o;
  assign cnt_dec = count_q - 1'b1;
  assign cnt_m1  = cnt_dec[IW-1:0];

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    ptr_d     = ptr_q;
    valid_d   = 1'b0;
    status_d  = pls_pkg::ST_OK;
    value_d   = '0;
    epos_d    = '0;
    last_d    = 1'b1;
    empty_d   = 1'b0;
    cmd.op    = pls_pkg::CELL_HOLD;
    cmd.value = value_in_i;
    cmd.head  = cell_data[0];
    cell_idx  = position_i[IW-1:0];
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (pls_pkg::func_e'(func_i))
            pls_pkg::OP_INSERT: begin
              valid_d = 1'b1;
              if (position_i > count_q) begin
                status_d = pls_pkg::ST_BADPOS;
              end else if (count_q == CapW) begin
                status_d = pls_pkg::ST_FULL;
              end else begin
                cmd.op  = pls_pkg::CELL_INSERT;
                count_d = count_q + 1'b1;
              end
            end
            pls_pkg::OP_UPDATE: begin
              valid_d = 1'b1;
              if (position_i >= count_q) status_d = pls_pkg::ST_BADPOS;
              else cmd.op = pls_pkg::CELL_WRITE;
            end
            pls_pkg::OP_DELETE: begin
              valid_d = 1'b1;
              if (position_i >= count_q) begin
                status_d = pls_pkg::ST_BADPOS;
              end else begin
                cmd.op  = pls_pkg::CELL_DELETE;
                count_d = cnt_dec;
              end
            end
            pls_pkg::OP_REVERSE: begin
              if (count_q > CW'(1)) begin
                state_d = S_REV;
                ptr_d   = cnt_m1;
              end else begin
                valid_d = 1'b1;
              end
            end
            pls_pkg::OP_PRINT: begin
              if (count_q == '0) begin
                valid_d = 1'b1;
                empty_d = 1'b1;
              end else begin
                state_d = S_PRINT;
                ptr_d   = '0;
              end
            end
            default: valid_d = 1'b1;
          endcase
        end
      end
      S_PRINT: begin
        // head word leaves, the row rotates so it returns to its place
        cmd.op   = pls_pkg::CELL_ROTATE;
        cell_idx = cnt_m1;
        valid_d  = 1'b1;
        value_d  = cell_data[0];
        epos_d   = ptr_q;
        last_d   = (ptr_q == cnt_m1);
        if (ptr_q == cnt_m1) state_d = S_IDLE;
        else ptr_d = ptr_q + 1'b1;
      end
      S_REV: begin
        // move head to the end of a shrinking window
        cmd.op   = pls_pkg::CELL_ROTATE;
        cell_idx = ptr_q;
        ptr_d    = ptr_q - 1'b1;
        if (ptr_q == IW'(1)) begin
          valid_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      count_q  <= '0;
      ptr_q    <= '0;
      valid_q  <= 1'b0;
      status_q <= pls_pkg::ST_OK;
      value_q  <= '0;
      epos_q   <= '0;
      last_q   <= 1'b0;
      empty_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      ptr_q    <= ptr_d;
      valid_q  <= valid_d;
      status_q <= status_d;
      value_q  <= value_d;
      epos_q   <= epos_d;
      last_q   <= last_d;
      empty_q  <= empty_d;
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [pls_pkg::DataW-1:0] left_w, right_w;
    if (i == 0) begin : g_first
      assign left_w = value_in_i;
    end else begin : g_mid_l
      assign left_w = cell_data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_w = cell_data[i];
    end else begin : g_mid_r
      assign right_w = cell_data[i+1];
    end
    pls_cell #(
      .IdxW  (IW),
      .Index (i)
    ) u_cell (
      .clk_i   (clk_i),
      .cmd_i   (cmd),
      .idx_i   (cell_idx),
      .left_i  (left_w),
      .right_i (right_w),
      .data_o  (cell_data[i])
    );
  end

  assign valid_o       = valid_q;
  assign status_o      = status_q;
  assign value_out_o   = value_q;
  assign entry_pos_o   = epos_q;
  assign is_last_o     = last_q;
  assign list_empty_o  = empty_q;
  assign entry_count_o = count_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CapW)
    else $error("entry count above capacity");

  a_empty_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && list_empty_o |-> is_last_o && (entry_count_o == '0))
    else $error("empty print word inconsistent");

  a_more_words: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !is_last_o |-> busy_o)
    else $error("non-final word while sequencer idle");

  a_quick_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && func_i != pls_pkg::OP_PRINT
      && func_i != pls_pkg::OP_REVERSE |=> valid_o)
    else $error("single-cycle operation gave no word");

  a_err_keeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && status_o != pls_pkg::ST_OK |-> $stable(count_q))
    else $error("error status but count changed");

endmodule

`default_nettype wire

@@ sim/pls_word_checker.sv @@
`timescale 1ns / 100ps
// pls_word_checker: keeps a shadow copy of the positional list, works out the result
// words of every accepted command and compares each strobed word in order.
// Depends on pls_pkg.
module pls_word_checker #(
  parameter int CAPACITY = pls_pkg::CapacityDef,
  localparam int IW = $clog2(CAPACITY),
  localparam int CW = $clog2(CAPACITY + 1)
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             start_i,
  input  wire logic                             busy_i,
  input  wire logic [2:0]                       func_i,
  input  wire logic [CW-1:0]                    position_i,
  input  wire logic signed [pls_pkg::DataW-1:0] value_in_i,
  input  wire logic                             valid_i,
  input  wire logic [1:0]                       status_i,
  input  wire logic signed [pls_pkg::DataW-1:0] value_out_i,
  input  wire logic [IW-1:0]                    entry_pos_i,
  input  wire logic                             is_last_i,
  input  wire logic                             list_empty_i,
  input  wire logic [CW-1:0]                    entry_count_i,
  output int                                    mismatch_cnt_o,
  output int                                    pending_o,
  output int                                    words_o,
  output int                                    full_hits_o,
  output int                                    badpos_hits_o,
  output int                                    peak_len_o
);
  import pls_pkg::*;

  typedef struct packed {
    logic [1:0]              status;
    logic signed [DataW-1:0] value;
    logic [IW-1:0]           pos;
    logic                    last;
    logic                    empty;
    logic [CW-1:0]           count;
  } list_word_t;

  logic signed [DataW-1:0] shadow_entries [CAPACITY];
  int                      shadow_len;
  list_word_t              expected_words [$];

  initial begin
    mismatch_cnt_o = 0;
    pending_o      = 0;
    words_o        = 0;
    full_hits_o    = 0;
    badpos_hits_o  = 0;
    peak_len_o     = 0;
    shadow_len     = 0;
  end

  function automatic list_word_t make_word(status_e st, logic signed [DataW-1:0] val,
                                           int idx, logic last, logic empty);
    list_word_t w;
    w.status = st;
    w.value  = val;
    w.pos    = IW'(idx);
    w.last   = last;
    w.empty  = empty;
    w.count  = CW'(shadow_len);
    return w;
  endfunction

  task automatic apply_command(input logic [2:0] code, input logic [CW-1:0] where,
                               input logic signed [DataW-1:0] val);
    status_e                 st;
    int                      p;
    int                      k;
    logic signed [DataW-1:0] tmp;
    st = ST_OK;
    p  = int'(where);
    case (code)
      OP_INSERT: begin
        if (p > shadow_len) begin
          st = ST_BADPOS;
        end else if (shadow_len >= CAPACITY) begin
          st = ST_FULL;
        end else begin
          for (k = shadow_len; k > p; k--) shadow_entries[k] = shadow_entries[k-1];
          shadow_entries[p] = val;
          shadow_len++;
        end
      end
      OP_UPDATE: begin
        if (p >= shadow_len) st = ST_BADPOS;
        else shadow_entries[p] = val;
      end
      OP_DELETE: begin
        if (p >= shadow_len) begin
          st = ST_BADPOS;
        end else begin
          for (k = p; k + 1 < shadow_len; k++) shadow_entries[k] = shadow_entries[k+1];
          shadow_len--;
        end
      end
      OP_REVERSE: begin
        for (k = 0; k < shadow_len / 2; k++) begin
          tmp = shadow_entries[k];
          shadow_entries[k] = shadow_entries[shadow_len-1-k];
          shadow_entries[shadow_len-1-k] = tmp;
        end
      end
      OP_PRINT: begin
        if (shadow_len == 0) begin
          expected_words.push_back(make_word(ST_OK, '0, 0, 1'b1, 1'b1));
        end else begin
          for (k = 0; k < shadow_len; k++)
            expected_words.push_back(make_word(ST_OK, shadow_entries[k], k,
                                               k == shadow_len - 1, 1'b0));
        end
        return;
      end
      default: ;
    endcase
    if (st == ST_FULL) full_hits_o++;
    if (st == ST_BADPOS) badpos_hits_o++;
    if (shadow_len > peak_len_o) peak_len_o = shadow_len;
    expected_words.push_back(make_word(st, '0, 0, 1'b1, 1'b0));
  endtask

  always @(posedge clk_i) begin
    list_word_t got;
    list_word_t want;
    if (!rst_ni) begin
      expected_words.delete();
      shadow_len = 0;
    end else begin
      if (start_i && !busy_i) apply_command(func_i, position_i, value_in_i);
      if (valid_i) begin
        got = '{status_i, value_out_i, entry_pos_i, is_last_i, list_empty_i, entry_count_i};
        words_o++;
        if (expected_words.size() == 0) begin
          mismatch_cnt_o++;
          if (mismatch_cnt_o <= 10)
            $display("word %0d unexpected: status %0d value %0d pos %0d last %0b empty %0b count %0d",
                     words_o, got.status, got.value, got.pos, got.last, got.empty, got.count);
        end else begin
          want = expected_words.pop_front();
          if (got !== want) begin
            mismatch_cnt_o++;
            if (mismatch_cnt_o <= 10) begin
              $display("word %0d expected: status %0d value %0d pos %0d last %0b empty %0b count %0d",
                       words_o, want.status, want.value, want.pos, want.last, want.empty,
                       want.count);
              $display("word %0d actual:   status %0d value %0d pos %0d last %0b empty %0b count %0d",
                       words_o, got.status, got.value, got.pos, got.last, got.empty, got.count);
            end
          end
        end
      end
    end
    pending_o = expected_words.size();
  end

endmodule

@@ sim/positional_list_store_test.sv @@
`timescale 1ns / 100ps
// positional_list_store_test: drives list commands into positional_list_store and gives
// the verdict; result words are checked by pls_word_checker. Depends on pls_pkg.
module positional_list_store_test;
  import pls_pkg::*;

  localparam int CAPACITY   = 16;
  localparam int IW         = $clog2(CAPACITY);
  localparam int CW         = $clog2(CAPACITY + 1);
  localparam int RandomCmds = 96;
  localparam int IdlePct    = 13;
  localparam int CycleLimit = 60000;
  localparam logic signed [DataW-1:0] MinValue = 32'sh8000_0000;
  localparam logic signed [DataW-1:0] MaxValue = 32'sh7fff_ffff;

  typedef enum {MODE_GROW, MODE_SHRINK, MODE_MIXED} mode_e;

  logic                    clk = 1'b0;
  logic                    rst_n;
  logic                    start;
  logic                    busy;
  logic [2:0]              func;
  logic [CW-1:0]           position;
  logic signed [DataW-1:0] value_in;
  logic                    valid;
  logic [1:0]              status;
  logic signed [DataW-1:0] value_out;
  logic [IW-1:0]           entry_pos;
  logic                    is_last;
  logic                    list_empty;
  logic [CW-1:0]           entry_count;

  int mismatches, pending, words, full_hits, badpos_hits, peak_len;
  int cycles = 0;
  int list_len = 0;
  int op_hits [8];
  bit quiet = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  positional_list_store #(.CAPACITY(CAPACITY)) dut (
    .clk_i(clk), .rst_ni(rst_n), .start_i(start), .busy_o(busy),
    .func_i(func), .position_i(position), .value_in_i(value_in),
    .valid_o(valid), .status_o(status), .value_out_o(value_out),
    .entry_pos_o(entry_pos), .is_last_o(is_last), .list_empty_o(list_empty),
    .entry_count_o(entry_count)
  );

  pls_word_checker #(.CAPACITY(CAPACITY)) u_words (
    .clk_i(clk), .rst_ni(rst_n), .start_i(start), .busy_i(busy),
    .func_i(func), .position_i(position), .value_in_i(value_in),
    .valid_i(valid), .status_i(status), .value_out_i(value_out),
    .entry_pos_i(entry_pos), .is_last_i(is_last), .list_empty_i(list_empty),
    .entry_count_i(entry_count),
    .mismatch_cnt_o(mismatches), .pending_o(pending), .words_o(words),
    .full_hits_o(full_hits), .badpos_hits_o(badpos_hits), .peak_len_o(peak_len)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d words outstanding", cycles, pending);
      $display("positional_list_store verification failed");
      $finish;
    end
  end

  task automatic send_command(input logic [2:0] code, input int where,
                              input logic signed [DataW-1:0] val);
    start    <= 1'b1;
    func     <= code;
    position <= CW'(where);
    value_in <= val;
    do @(posedge clk); while (busy);
    op_hits[code]++;
    // track the length only, for picking useful positions
    if (code == OP_INSERT && where <= list_len && list_len < CAPACITY) list_len++;
    if (code == OP_DELETE && where < list_len) list_len--;
    if (!quiet && $urandom_range(0, 99) < IdlePct) begin
      start    <= 1'b0;
      func     <= 3'($urandom);
      value_in <= $urandom;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  function automatic logic [2:0] pick_op(mode_e mode);
    int r;
    int ins_cut, upd_cut, del_cut, rev_cut, prt_cut;
    r = $urandom_range(0, 99);
    case (mode)
      MODE_GROW:   begin ins_cut = 70; upd_cut = 78; del_cut = 83; rev_cut = 88; prt_cut = 96; end
      MODE_SHRINK: begin ins_cut = 15; upd_cut = 25; del_cut = 75; rev_cut = 82; prt_cut = 95; end
      default:     begin ins_cut = 30; upd_cut = 45; del_cut = 65; rev_cut = 75; prt_cut = 93; end
    endcase
    if (r < ins_cut) return OP_INSERT;
    if (r < upd_cut) return OP_UPDATE;
    if (r < del_cut) return OP_DELETE;
    if (r < rev_cut) return OP_REVERSE;
    if (r < prt_cut) return OP_PRINT;
    return 3'(int'(OP_PRINT) + 1 + $urandom_range(0, 2));
  endfunction

  function automatic logic signed [DataW-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return MinValue;
      1:       return MaxValue;
      2:       return '0;
      3:       return '1;
      default: return $urandom;
    endcase
  endfunction

  task automatic random_command(input mode_e mode);
    logic [2:0] code;
    int         where;
    code = pick_op(mode);
    if ($urandom_range(0, 99) < 12 || code > OP_DELETE) where = $urandom_range(0, 31);
    else if (code == OP_INSERT) where = $urandom_range(0, list_len);
    else if (list_len == 0) where = 0;
    else where = $urandom_range(0, list_len - 1);
    send_command(code, where, pick_value());
  endtask

  initial begin
    mode_e schedule [4];
    rst_n    = 1'b0;
    start    = 1'b0;
    func     = OP_INSERT;
    position = '0;
    value_in = '0;
    schedule = '{MODE_GROW, MODE_SHRINK, MODE_GROW, MODE_MIXED};
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty list corners
    send_command(OP_PRINT, 0, 0);
    send_command(OP_REVERSE, 31, MaxValue);
    send_command(OP_UPDATE, 0, MaxValue);
    send_command(OP_DELETE, 0, 0);
    send_command(OP_INSERT, 1, MinValue);
    // build, rearrange and bounds
    send_command(OP_INSERT, 0, MinValue);
    send_command(OP_INSERT, 1, MaxValue);
    send_command(OP_INSERT, 3, 32'sd5);
    send_command(OP_INSERT, 1, 0);
    send_command(OP_PRINT, 0, 0);
    send_command(OP_REVERSE, 0, 0);
    send_command(OP_PRINT, 17, MinValue);
    send_command(OP_UPDATE, 2, -1);
    send_command(OP_UPDATE, 3, 32'sd7);
    send_command(OP_DELETE, 1, MaxValue);
    send_command(OP_DELETE, 2, 0);
    send_command(OP_REVERSE, 0, 0);
    send_command(OP_PRINT, 0, 0);
    send_command(OP_DELETE, 0, 0);
    send_command(OP_REVERSE, 0, 0);
    send_command(OP_PRINT, 0, 0);
    for (int c = int'(OP_PRINT) + 1; c < 8; c++) send_command(3'(c), 31, $urandom);
    send_command(OP_INSERT, 31, MaxValue);

    for (int i = 0; i < RandomCmds; i++) begin
      quiet = (i >= 40 && i < 80);
      random_command(schedule[(i / 30) % 4]);
    end
    start <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (2 * CAPACITY + 8) @(posedge clk);

    $display("commands: %0d insert, %0d update, %0d delete, %0d reverse, %0d print, %0d other",
             op_hits[OP_INSERT], op_hits[OP_UPDATE], op_hits[OP_DELETE], op_hits[OP_REVERSE],
             op_hits[OP_PRINT], op_hits[5] + op_hits[6] + op_hits[7]);
    $display("%0d words checked, %0d full rejects, %0d bad positions, peak length %0d",
             words, full_hits, badpos_hits, peak_len);
    if (mismatches == 0 && pending == 0) begin
      $display("positional_list_store verification clean");
    end else begin
      $display("positional_list_store verification failed");
    end
    $finish;
  end

endmodule
